// ----- rtl/mbcrc_pkg.sv -----
// Package for the Modbus RTU framing encoder: request types, register indexes and the CRC step.
package mbcrc_pkg;

  // Configuration register indexes and widths.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_STATION_ADDRESS     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS_AFTER_FIRST = 8'd1;

  // Reset values of the registers and of the CRC.
  localparam logic [7:0]  STATION_ADDRESS_RESET = 8'h01;
  localparam logic [15:0] CRC_INIT              = 16'hFFFF;
  localparam logic [15:0] CRC_POLY              = 16'hA001;

  // Largest number of line bytes that one payload request can cause.
  localparam int GROUP_MAX = 4;
  localparam int GROUP_CNT_W = $clog2(GROUP_MAX + 1);
  localparam int GROUP_IDX_W = $clog2(GROUP_MAX);

  // Input request: one payload byte and its last-byte flag.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_last;
  } in_item_t;

  // Output request: one line byte and the frame-end mark.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
  } out_item_t;

  // Configuration write as seen by the framer.
  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

  // Group of line bytes produced from one payload request.
  typedef struct packed {
    out_item_t [GROUP_MAX-1:0] items;
    logic [GROUP_CNT_W-1:0]    count;
  } group_t;

  // Fold one byte into the reflected Modbus CRC-16.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/mbcrc_framer.sv -----
// Framer: input register, configuration registers, CRC state and the byte group of one request.
module mbcrc_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mbcrc_pkg::in_item_t in_data,
  input  mbcrc_pkg::cfg_wr_t  cfg,
  input  logic                grp_ready,
  output logic                grp_valid,
  output mbcrc_pkg::group_t   grp
);

  logic                hold_valid;
  mbcrc_pkg::in_item_t hold;
  logic [7:0]          station_address;
  logic                address_after_first;
  logic [15:0]         crc;
  logic                at_frame_start;

  logic                grp_load;
  logic [7:0]          first_byte;
  logic [7:0]          second_byte;
  logic [15:0]         crc_first;
  logic [15:0]         crc_next;
  logic                at_frame_start_next;

  // The held request moves on when the output buffer can take its group.
  assign grp_valid = hold_valid;
  assign grp_load  = hold_valid && grp_ready;
  assign in_stall  = hold_valid && !grp_ready;

  // Input register: takes a new request whenever the held one leaves or none is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold <= in_data;
    end
  end

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      station_address     <= mbcrc_pkg::STATION_ADDRESS_RESET;
      address_after_first <= 1'b0;
    end else if (cfg.en) begin
      if (cfg.index == mbcrc_pkg::CFG_STATION_ADDRESS) begin
        station_address <= cfg.data;
      end else if (cfg.index == mbcrc_pkg::CFG_ADDRESS_AFTER_FIRST) begin
        address_after_first <= cfg.data[0];
      end
    end
  end

  // Order the address and payload bytes, and fold the data bytes into the CRC.
  always_comb begin
    if (at_frame_start && !address_after_first) begin
      first_byte  = station_address;
      second_byte = hold.payload_byte;
    end else begin
      first_byte  = hold.payload_byte;
      second_byte = station_address;
    end
    crc_first = mbcrc_pkg::crc_fold(crc, first_byte);
    if (at_frame_start) begin
      crc_next = mbcrc_pkg::crc_fold(crc_first, second_byte);
    end else begin
      crc_next = crc_first;
    end
    at_frame_start_next = hold.payload_last;
  end

  // Build the group: data bytes first, then CRC low and high on the last byte.
  always_comb begin
    grp.items[0] = '{line_byte: first_byte, frame_end: 1'b0};
    if (at_frame_start) begin
      grp.items[1] = '{line_byte: second_byte, frame_end: 1'b0};
      grp.items[2] = '{line_byte: crc_next[7:0], frame_end: 1'b0};
      grp.items[3] = '{line_byte: crc_next[15:8], frame_end: 1'b1};
    end else begin
      grp.items[1] = '{line_byte: crc_next[7:0], frame_end: 1'b0};
      grp.items[2] = '{line_byte: crc_next[15:8], frame_end: 1'b1};
      grp.items[3] = '{line_byte: crc_next[15:8], frame_end: 1'b1};
    end
    grp.count = (at_frame_start ? mbcrc_pkg::GROUP_CNT_W'(2) : mbcrc_pkg::GROUP_CNT_W'(1))
              + (hold.payload_last ? mbcrc_pkg::GROUP_CNT_W'(2) : mbcrc_pkg::GROUP_CNT_W'(0));
  end

  // Frame state advances when the group is handed over.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc            <= mbcrc_pkg::CRC_INIT;
      at_frame_start <= 1'b1;
    end else if (grp_load) begin
      crc            <= hold.payload_last ? mbcrc_pkg::CRC_INIT : crc_next;
      at_frame_start <= at_frame_start_next;
    end
  end

endmodule

// ----- rtl/mbcrc_outbuf.sv -----
// Output buffer: holds one group of line bytes and sends them one per cycle while out_stall is low.
module mbcrc_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 grp_valid,
  input  mbcrc_pkg::group_t    grp,
  output logic                 grp_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mbcrc_pkg::out_item_t out_data
);

  mbcrc_pkg::out_item_t                 items [mbcrc_pkg::GROUP_MAX];
  logic [mbcrc_pkg::GROUP_CNT_W-1:0]    remaining;
  logic [mbcrc_pkg::GROUP_IDX_W-1:0]    head;
  logic                                 pop;
  logic                                 load;

  // A new group may enter once the buffer is empty or its last byte leaves now.
  assign out_valid = (remaining != '0);
  assign pop       = out_valid && !out_stall;
  assign grp_ready = (remaining == '0)
                   || ((remaining == mbcrc_pkg::GROUP_CNT_W'(1)) && pop);
  assign load      = grp_valid && grp_ready;
  assign out_data  = items[head];

  // Byte count and read pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      head      <= '0;
    end else if (load) begin
      remaining <= grp.count;
      head      <= '0;
    end else if (pop) begin
      remaining <= remaining - mbcrc_pkg::GROUP_CNT_W'(1);
      head      <= head + mbcrc_pkg::GROUP_IDX_W'(1);
    end
  end

  // Byte storage, loaded as a whole group.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < mbcrc_pkg::GROUP_MAX; i++) begin
        items[i] <= grp.items[i];
      end
    end
  end

endmodule

// ----- rtl/modbus_rtu_frame_crc_encoder.sv -----
// Top level of the Modbus RTU framing encoder with CRC-16.
// Payload bytes enter one per request; the station address is added before the first byte
// (or after it when address_after_first is set), and the CRC low and high bytes follow the
// last byte, the high byte marked with frame_end. Each payload request yields one line byte,
// two at the start of a frame, plus two CRC bytes on the last one, and the output sends one
// byte per cycle while out_stall is low; an input register in front of the four-byte output
// buffer takes the next request while the current group is still being sent. The CRC steps
// of a request are computed combinationally between the input register and the output
// buffer. Configuration writes are always accepted and are meant to be made while the block
// is idle.
module modbus_rtu_frame_crc_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mbcrc_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mbcrc_pkg::out_item_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbcrc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mbcrc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  mbcrc_pkg::cfg_wr_t cfg;
  mbcrc_pkg::group_t  grp;
  logic               grp_valid;
  logic               grp_ready;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;
  assign cfg.en    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  mbcrc_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .grp_ready (grp_ready),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  mbcrc_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_ready (grp_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/mbcrc_checker.sv -----
// Port checker for the Modbus RTU framing encoder, bound to the top level.
module mbcrc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input mbcrc_pkg::out_item_t out_data
);

  // Nothing is offered on the output straight after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output request offered right after reset");

  // A stalled output request holds its bytes.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output request changed");

  // With nothing waiting at the output the input is never stalled.
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("input stalled while the output is empty");

  // The byte after a frame end opens a new frame and cannot close one.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.frame_end) |=> !(out_valid && out_data.frame_end))
    else $error("two frame ends in a row");

endmodule

bind modbus_rtu_frame_crc_encoder mbcrc_checker u_mbcrc_checker (.*);
